>>> rtl/core/lcdns_pkg.sv
// Shared types, codes and the microcode ROM of the LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none

package lcdns_pkg;

  localparam int unsigned PC_W        = 6;
  localparam int unsigned SHORT_W     = 10;
  localparam int unsigned EXEC_W      = 10;
  localparam int unsigned INIT_W      = 16;
  localparam int unsigned PAUSE_W     = 17;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [SHORT_W-1:0] SHORT_PAUSE_RST = SHORT_W'(1);
  localparam logic [EXEC_W-1:0]  EXEC_PAUSE_RST  = EXEC_W'(100);
  localparam logic [INIT_W-1:0]  INIT_PAUSE_RST  = INIT_W'(5000);

  // command codes
  localparam logic [2:0] CMD_INIT   = 3'd0;
  localparam logic [2:0] CMD_CLEAR  = 3'd1;
  localparam logic [2:0] CMD_HOME   = 3'd2;
  localparam logic [2:0] CMD_DISP   = 3'd3;
  localparam logic [2:0] CMD_RIGHT  = 3'd4;
  localparam logic [2:0] CMD_LEFT   = 3'd5;
  localparam logic [2:0] CMD_GOTO   = 3'd6;
  localparam logic [2:0] CMD_CHAR   = 3'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXEC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT  = 2'd2;

  // program entry points
  localparam logic [PC_W-1:0] ENTRY_INIT = 6'd0;
  localparam logic [PC_W-1:0] ENTRY_CMD  = 6'd48;
  localparam logic [PC_W-1:0] ENTRY_CHAR = 6'd56;

  // instruction bytes on the bus
  localparam logic [7:0] OP_CLEAR = 8'h01;
  localparam logic [7:0] OP_HOME  = 8'h02;
  localparam logic [7:0] OP_DISP  = 8'h0C;
  localparam logic [7:0] OP_RIGHT = 8'h14;
  localparam logic [7:0] OP_LEFT  = 8'h10;

  localparam logic [7:0] GOTO_ADDR [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

  // nibbles of the init program: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
  localparam logic [3:0] INIT_NIB [12] = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8,
                                          4'h0, 4'hC, 4'h0, 4'h1, 4'h0, 4'h6};

  typedef enum logic [1:0] {
    DSEL_ZERO,
    DSEL_CONST,
    DSEL_HI,
    DSEL_LO
  } dsel_t;

  typedef enum logic [2:0] {
    XSEL_NONE,
    XSEL_SHORT,
    XSEL_EXEC,
    XSEL_INIT,
    XSEL_CMD
  } xsel_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    dsel_t      dsel;
    logic [3:0] nib;
    logic       pause_exec;
    xsel_t      xsel;
    logic       last;
  } ctrl_t;

  // one control word per emitted byte
  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t      w;
    logic [3:0] k;
    logic [1:0] s;
    w = '0;
    k = pc[5:2];
    s = pc[1:0];
    if (pc < ENTRY_CHAR) begin
      // nibble strobe: idle, enable, enable with data, data
      w.en         = (s == 2'd1) || (s == 2'd2);
      w.pause_exec = (s == 2'd2);
      if (s[1]) begin
        if (pc < ENTRY_CMD) begin
          w.dsel = DSEL_CONST;
        end else if (k == 4'd12) begin
          w.dsel = DSEL_HI;
        end else begin
          w.dsel = DSEL_LO;
        end
      end
      if (pc < ENTRY_CMD) begin
        w.nib = INIT_NIB[k];
      end
      if (s == 2'd3) begin
        if (pc < ENTRY_CMD) begin
          case (k)
            4'd0:                      w.xsel = XSEL_INIT;
            4'd1, 4'd2, 4'd3:          w.xsel = XSEL_SHORT;
            4'd5, 4'd7, 4'd9, 4'd11:   w.xsel = XSEL_EXEC;
            default:                   w.xsel = XSEL_NONE;
          endcase
          w.last = (k == 4'd11);
        end else if (k == 4'd13) begin
          w.xsel = XSEL_CMD;
          w.last = 1'b1;
        end
      end
    end else begin
      w.rs = 1'b1;
      case (pc - ENTRY_CHAR)
        6'd0: ;
        6'd1: w.en = 1'b1;
        6'd2: begin
          w.en = 1'b1; w.dsel = DSEL_HI; w.pause_exec = 1'b1;
        end
        6'd3: w.dsel = DSEL_HI;
        6'd4: begin
          w.en = 1'b1; w.dsel = DSEL_LO; w.pause_exec = 1'b1;
        end
        6'd5: w.dsel = DSEL_LO;
        default: begin
          // RS drops on the last byte
          w.rs = 1'b0; w.dsel = DSEL_LO; w.last = 1'b1;
        end
      endcase
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lcdns_ucode.sv
// Step counter and control store of the LCD nibble sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcdns_ucode (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [lcdns_pkg::PC_W-1:0] entry,
  input  wire logic                    advance,
  output lcdns_pkg::ctrl_t             word,
  output logic                         busy
);

  logic [lcdns_pkg::PC_W-1:0] pc;

  assign word = lcdns_pkg::rom_word(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= entry;
    end else if (advance) begin
      // end-of-program word returns to fetch, otherwise step on
      if (word.last) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/char_lcd_nibble_sequencer_unit.sv
// Top level: command in, stream of expander port bytes with pauses out.
//
// A command arrives on the s_ channel; it expands into a run of port bytes on
// the m_ channel, each with the pause to wait after it and tlast on the final
// byte. Runs are 48 bytes for init, 8 for an instruction command, 7 for a
// character. A microcode program in a ROM yields one byte per cycle while
// the output is not stalled; the step counter walks it and the last word of
// each program ends the run. The command transfer loads the step counter;
// each byte then goes through the output register to m_tdata, one per
// cycle while m_tready is high. s_tready is low while a run is in progress.
// A stall on m_tready holds the output register and freezes the program.
// The cfg channel is always ready; writes are meant while the block is idle.
// Reset empties the output register, stops the program and restores the
// pause registers to 1, 100 and 5000 microseconds.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // command[2:0] line_index[4:3] char_code[12:5]
                                      // cursor_on[13] blink_on[14]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // port_byte[7:0] pause_us[24:8]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [lcdns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcdns_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] command;
  logic [1:0] line_index;
  logic [7:0] char_code;
  logic       cursor_on;
  logic       blink_on;

  assign command    = s_tdata[2:0];
  assign line_index = s_tdata[4:3];
  assign char_code  = s_tdata[12:5];
  assign cursor_on  = s_tdata[13];
  assign blink_on   = s_tdata[14];

  logic [lcdns_pkg::SHORT_W-1:0] short_pause;
  logic [lcdns_pkg::EXEC_W-1:0]  exec_pause;
  logic [lcdns_pkg::INIT_W-1:0]  init_pause;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_pause <= lcdns_pkg::SHORT_PAUSE_RST;
      exec_pause  <= lcdns_pkg::EXEC_PAUSE_RST;
      init_pause  <= lcdns_pkg::INIT_PAUSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcdns_pkg::REG_SHORT: short_pause <= cfg_data[lcdns_pkg::SHORT_W-1:0];
        lcdns_pkg::REG_EXEC:  exec_pause  <= cfg_data[lcdns_pkg::EXEC_W-1:0];
        lcdns_pkg::REG_INIT:  init_pause  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand byte and program entry decoded at command transfer
  logic                         start;
  logic                         busy;
  logic                         advance;
  logic [7:0]                   op_next;
  logic [lcdns_pkg::PC_W-1:0]   entry;
  logic [7:0]                   op;
  logic                         is_goto;
  lcdns_pkg::ctrl_t             word;

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign advance  = busy && (!m_tvalid || m_tready);

  always_comb begin
    op_next = char_code;
    entry   = lcdns_pkg::ENTRY_CMD;
    case (command)
      lcdns_pkg::CMD_INIT:  entry   = lcdns_pkg::ENTRY_INIT;
      lcdns_pkg::CMD_CLEAR: op_next = lcdns_pkg::OP_CLEAR;
      lcdns_pkg::CMD_HOME:  op_next = lcdns_pkg::OP_HOME;
      lcdns_pkg::CMD_DISP:  op_next = lcdns_pkg::OP_DISP | {6'd0, cursor_on, blink_on};
      lcdns_pkg::CMD_RIGHT: op_next = lcdns_pkg::OP_RIGHT;
      lcdns_pkg::CMD_LEFT:  op_next = lcdns_pkg::OP_LEFT;
      lcdns_pkg::CMD_GOTO:  op_next = lcdns_pkg::GOTO_ADDR[line_index];
      default:              entry   = lcdns_pkg::ENTRY_CHAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op      <= op_next;
      is_goto <= (command == lcdns_pkg::CMD_GOTO);
    end
  end

  lcdns_ucode u_ucode (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .entry   (entry),
    .advance (advance),
    .word    (word),
    .busy    (busy)
  );

  // datapath driven by the control word
  logic [3:0]                     nib;
  logic [7:0]                     port_byte_next;
  logic [lcdns_pkg::SHORT_W-1:0]  base_pause;
  logic [lcdns_pkg::INIT_W-1:0]   extra_pause;
  logic [lcdns_pkg::PAUSE_W-1:0]  pause_next;

  always_comb begin
    case (word.dsel)
      lcdns_pkg::DSEL_CONST: nib = word.nib;
      lcdns_pkg::DSEL_HI:    nib = op[7:4];
      lcdns_pkg::DSEL_LO:    nib = op[3:0];
      default:               nib = 4'd0;
    endcase
    // data, backlight, EN, RW low, RS
    port_byte_next = {nib, 1'b1, word.en, 1'b0, word.rs};
    base_pause = word.pause_exec ? exec_pause : short_pause;
    case (word.xsel)
      lcdns_pkg::XSEL_SHORT: extra_pause = {6'd0, short_pause};
      lcdns_pkg::XSEL_EXEC:  extra_pause = {6'd0, exec_pause};
      lcdns_pkg::XSEL_INIT:  extra_pause = init_pause;
      lcdns_pkg::XSEL_CMD:   extra_pause = {6'd0, is_goto ? short_pause : exec_pause};
      default:               extra_pause = '0;
    endcase
    pause_next = {7'd0, base_pause} + {1'b0, extra_pause};
  end

  logic [7:0]                    port_byte;
  logic [lcdns_pkg::PAUSE_W-1:0] pause_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      m_tlast  <= word.last;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      port_byte <= port_byte_next;
      pause_us  <= pause_next;
    end
  end

  assign m_tdata = {7'd0, pause_us, port_byte};

endmodule

`default_nettype wire

>>> rtl/core/lcdns_checker.sv
// Port-level checks of the LCD nibble sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcdns_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  // a transfer starts a run, so the input is closed in the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a command transfer");

  // while idle, only the final byte of a run may still be waiting
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast)
    else $error("input ready with a run still in flight");

  // nothing comes out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

endmodule

bind char_lcd_nibble_sequencer_unit lcdns_checker u_lcdns_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

>>> sim/tb.sv
// Testbench for the LCD nibble sequencer: command stream in, expander bytes out.
`timescale 1ns / 1ps

module tb;
  import lcdns_pkg::*;

  // expander port bits
  localparam logic [7:0] PB_RS = 8'h01;
  localparam logic [7:0] PB_EN = 8'h04;
  localparam logic [7:0] PB_BL = 8'h08;

  // init program pieces
  localparam logic [3:0] WAKE_NIB    = 4'h3;
  localparam logic [3:0] FOURBIT_NIB = 4'h2;
  localparam logic [7:0] FUNC_SET    = 8'h28;
  localparam logic [7:0] ENTRY_MODE  = 8'h06;

  // index past the last register; the block ignores it
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;

  typedef struct packed {
    logic [7:0]         port;
    logic [PAUSE_W-1:0] pause;
    logic               last;
  } port_beat_t;

  class lcd_bus_scoreboard;
    logic [SHORT_W-1:0] short_us;
    logic [EXEC_W-1:0]  exec_us;
    logic [INIT_W-1:0]  init_us;
    port_beat_t         run[$];
    port_beat_t         due_beats[$];
    int                 errors;

    function new();
      short_us = SHORT_PAUSE_RST;
      exec_us  = EXEC_PAUSE_RST;
      init_us  = INIT_PAUSE_RST;
      errors   = 0;
    endfunction

    task report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHORT: short_us = data[SHORT_W-1:0];
        REG_EXEC:  exec_us  = data[EXEC_W-1:0];
        REG_INIT:  init_us  = data[INIT_W-1:0];
        default: ;
      endcase
    endfunction

    function void put(input logic [7:0] b, input logic [PAUSE_W-1:0] p);
      port_beat_t e;
      e.port  = b;
      e.pause = p;
      e.last  = 1'b0;
      run.push_back(e);
    endfunction

    function void add_pause(input logic [PAUSE_W-1:0] x);
      run[$].pause = run[$].pause + x;
    endfunction

    function void nibble(input logic [3:0] n);
      logic [7:0] d;
      d = {n, 4'h0};
      put(PB_BL, PAUSE_W'(short_us));
      put(PB_EN | PB_BL, PAUSE_W'(short_us));
      put(d | PB_EN | PB_BL, PAUSE_W'(exec_us));
      put(d | PB_BL, PAUSE_W'(short_us));
    endfunction

    function void instr(input logic [7:0] b, input logic [PAUSE_W-1:0] extra);
      nibble(b[7:4]);
      nibble(b[3:0]);
      add_pause(extra);
    endfunction

    function void character(input logic [7:0] c);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {c[7:4], 4'h0};
      lo = {c[3:0], 4'h0};
      put(PB_RS | PB_BL, PAUSE_W'(short_us));
      put(PB_RS | PB_EN | PB_BL, PAUSE_W'(short_us));
      put(hi | PB_RS | PB_EN | PB_BL, PAUSE_W'(exec_us));
      put(hi | PB_RS | PB_BL, PAUSE_W'(short_us));
      put(lo | PB_RS | PB_EN | PB_BL, PAUSE_W'(exec_us));
      put(lo | PB_RS | PB_BL, PAUSE_W'(short_us));
      put(lo | PB_BL, PAUSE_W'(short_us));
    endfunction

    // expand one accepted command into its byte run
    function void take_command(input logic [15:0] word);
      logic [2:0] cmd;
      logic [1:0] line;
      logic [7:0] ch;
      logic       cur;
      logic       blink;
      cmd   = word[2:0];
      line  = word[4:3];
      ch    = word[12:5];
      cur   = word[13];
      blink = word[14];
      run.delete();
      case (cmd)
        CMD_INIT: begin
          nibble(WAKE_NIB);
          add_pause(PAUSE_W'(init_us));
          nibble(WAKE_NIB);
          add_pause(PAUSE_W'(short_us));
          nibble(WAKE_NIB);
          add_pause(PAUSE_W'(short_us));
          nibble(FOURBIT_NIB);
          add_pause(PAUSE_W'(short_us));
          instr(FUNC_SET, PAUSE_W'(exec_us));
          instr(OP_DISP, PAUSE_W'(exec_us));
          instr(OP_CLEAR, PAUSE_W'(exec_us));
          instr(ENTRY_MODE, PAUSE_W'(exec_us));
        end
        CMD_CLEAR: instr(OP_CLEAR, PAUSE_W'(exec_us));
        CMD_HOME:  instr(OP_HOME, PAUSE_W'(exec_us));
        CMD_DISP:  instr(OP_DISP | {6'b0, cur, blink}, PAUSE_W'(exec_us));
        CMD_RIGHT: instr(OP_RIGHT, PAUSE_W'(exec_us));
        CMD_LEFT:  instr(OP_LEFT, PAUSE_W'(exec_us));
        CMD_GOTO:  instr(GOTO_ADDR[line], PAUSE_W'(short_us));
        default:   character(ch);
      endcase
      run[$].last = 1'b1;
      foreach (run[i]) due_beats.push_back(run[i]);
    endfunction

    task check_byte(input logic [7:0] port, input logic [PAUSE_W-1:0] pause,
                    input logic last);
      port_beat_t e;
      if (due_beats.size() == 0) begin
        report($sformatf("byte %h with nothing pending", port));
      end else begin
        e = due_beats.pop_front();
        if (port !== e.port)
          report($sformatf("port byte %h, want %h", port, e.port));
        if (pause !== e.pause)
          report($sformatf("pause %0d, want %0d (byte %h)", pause, e.pause, e.port));
        if (last !== e.last)
          report($sformatf("tlast %b, want %b (byte %h)", last, e.last, e.port));
      end
    endtask

    function int pending();
      return due_beats.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [31:0]           m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcd_bus_scoreboard sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;
  bit long_hold_req;
  int quiet_cycles;

  char_lcd_nibble_sequencer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (long_hold_req && m_tvalid) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // output check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_byte(m_tdata[7:0], m_tdata[8 +: PAUSE_W], m_tlast);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [15:0] pack_cmd(input logic [2:0] cmd, input logic [1:0] line,
                                           input logic [7:0] ch, input logic cur,
                                           input logic blink);
    return {1'b0, blink, cur, ch, line, cmd};
  endfunction

  // called just after a falling edge; returns just after one
  task send_cmd(input logic [15:0] word);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.take_command(word);
    @(negedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  task set_pauses(input logic [CFG_DATA_W-1:0] s, input logic [CFG_DATA_W-1:0] e,
                  input logic [CFG_DATA_W-1:0] i);
    write_reg(REG_SHORT, s);
    write_reg(REG_EXEC, e);
    write_reg(REG_INIT, i);
    cfg_valid <= 1'b0;
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task run_random(input int n_items, input int tx_pct, input int rx_pct, input bit hold);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    long_hold_req = hold;
    repeat (n_items) send_cmd(16'($urandom_range(0, 16'h7FFF)));
    wait_drained();
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_left     = 0;
    long_hold_req = 1'b0;
    quiet_cycles  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every command at reset pauses, unused fields at varied values
    send_cmd(pack_cmd(CMD_INIT, 2'd3, 8'hFF, 1'b1, 1'b1));
    send_cmd(pack_cmd(CMD_CLEAR, 2'd3, 8'hFF, 1'b1, 1'b1));
    send_cmd(pack_cmd(CMD_HOME, 2'd0, 8'h00, 1'b0, 1'b0));
    send_cmd(pack_cmd(CMD_DISP, 2'd0, 8'h00, 1'b0, 1'b0));
    send_cmd(pack_cmd(CMD_DISP, 2'd0, 8'h00, 1'b1, 1'b0));
    // cursor off with blink on
    send_cmd(pack_cmd(CMD_DISP, 2'd3, 8'hFF, 1'b0, 1'b1));
    send_cmd(pack_cmd(CMD_DISP, 2'd0, 8'h00, 1'b1, 1'b1));
    send_cmd(pack_cmd(CMD_RIGHT, 2'd1, 8'h5A, 1'b1, 1'b0));
    send_cmd(pack_cmd(CMD_LEFT, 2'd2, 8'hA5, 1'b0, 1'b1));
    send_cmd(pack_cmd(CMD_GOTO, 2'd0, 8'hFF, 1'b1, 1'b1));
    send_cmd(pack_cmd(CMD_GOTO, 2'd1, 8'h00, 1'b0, 1'b0));
    send_cmd(pack_cmd(CMD_GOTO, 2'd2, 8'hFF, 1'b0, 1'b1));
    send_cmd(pack_cmd(CMD_GOTO, 2'd3, 8'h00, 1'b1, 1'b0));
    send_cmd(pack_cmd(CMD_CHAR, 2'd0, 8'h00, 1'b0, 1'b0));
    send_cmd(pack_cmd(CMD_CHAR, 2'd3, 8'hFF, 1'b1, 1'b1));
    send_cmd(pack_cmd(CMD_CHAR, 2'd1, 8'hA5, 1'b0, 1'b1));
    send_cmd(pack_cmd(CMD_CHAR, 2'd2, 8'h5A, 1'b1, 1'b0));
    wait_drained();

    // all pauses zero, then a write to the unused index
    set_pauses(16'h0000, 16'h0000, 16'h0000);
    write_reg(REG_NONE, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_cmd(pack_cmd(CMD_INIT, 2'd0, 8'h00, 1'b0, 1'b0));
    send_cmd(pack_cmd(CMD_GOTO, 2'd2, 8'h3C, 1'b0, 1'b0));
    run_random(110, 0, 0, 1'b0);

    // maximum pauses; upper data bits of the short registers get dropped
    set_pauses(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(pack_cmd(CMD_INIT, 2'd1, 8'h81, 1'b1, 1'b0));
    send_cmd(pack_cmd(CMD_CHAR, 2'd1, 8'hC3, 1'b0, 1'b0));
    run_random(120, 81, 0, 1'b0);

    set_pauses(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
               16'($urandom_range(0, 65535)));
    run_random(120, 0, 81, 1'b1);

    set_pauses(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
               16'($urandom_range(0, 65535)));
    run_random(120, 8, 8, 1'b0);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
